FILE: rtl/bug2_pkg.sv
// Shared types, constants and the arctangent table of the Bug2 navigation controller.
// Used by the controller, the datapath and the top level; depends on nothing else.
package bug2_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_IDX_W       = 5;

  localparam logic signed [31:0] PI_Q24      = 32'sd52707179;
  localparam logic signed [31:0] TWO_PI_Q24  = 32'sd105414358;
  localparam logic signed [31:0] HALF_PI_Q24 = 32'sd26353589;

  localparam logic signed [15:0] ANG_SLOW  = 16'sd819;
  localparam logic signed [15:0] ANG_FAST  = 16'sd3277;
  localparam logic signed [15:0] LIN_SPEED = 16'sd410;

  localparam logic [2:0] ACT_TURN_LEFT  = 3'd0;
  localparam logic [2:0] ACT_TURN_RIGHT = 3'd1;
  localparam logic [2:0] ACT_ALIGNED    = 3'd2;
  localparam logic [2:0] ACT_FORWARD    = 3'd3;
  localparam logic [2:0] ACT_GOAL_STOP  = 3'd4;
  localparam logic [2:0] ACT_FIND_WALL  = 3'd5;
  localparam logic [2:0] ACT_GO_LEFT    = 3'd6;
  localparam logic [2:0] ACT_FOLLOW     = 3'd7;

  localparam logic [2:0] CFG_OBSTACLE   = 3'd0;
  localparam logic [2:0] CFG_FRONT_MIN  = 3'd1;
  localparam logic [2:0] CFG_LEAVE_LINE = 3'd2;
  localparam logic [2:0] CFG_GOAL_DIST  = 3'd3;
  localparam logic [2:0] CFG_YAW_TOL    = 3'd4;
  localparam logic [2:0] CFG_TICKS      = 3'd5;
  localparam logic [2:0] CFG_FOLLOW_MIN = 3'd6;

  typedef struct packed {
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic [15:0]        range_front;
    logic [15:0]        range_left;
    logic [15:0]        range_right;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] linear_velocity;
    logic signed [15:0] angular_velocity;
    logic [2:0]         action;
  } out_word_t;

  typedef enum logic [1:0] {
    PH_TURN = 2'd0,
    PH_GO   = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    MOP_DX, MOP_DY, MOP_GD, MOP_GXPY, MOP_GYPX, MOP_GXGX, MOP_GYGY,
    MOP_LD, MOP_CC, MOP_LG
  } mop_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CORD_INIT, S_CORD_NORM, S_CORD_ITER, S_ERR_INIT, S_ERR_WRAP,
    S_MUL_LOAD, S_MUL_RUN, S_MUL_WB, S_CROSS, S_DECIDE, S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic cord_init;
    logic cord_norm;
    logic cord_iter;
    logic err_init;
    logic err_wrap;
    logic mul_load;
    logic mul_run;
    logic mul_wb;
    logic cross_calc;
    logic decide;
    logic emit;
    mop_t mop;
  } cmd_t;

  typedef struct packed {
    logic   wall_mode;
    phase_t phase;
    logic   zero;
    logic   norm_done;
    logic   cord_last;
    logic   err_ok;
    logic   mul_last;
    logic   res_has;
    logic   out_free;
  } status_t;

  function automatic logic signed [31:0] atan_q24(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:  v = 32'sd13176795;
      5'd1:  v = 32'sd7778716;
      5'd2:  v = 32'sd4110060;
      5'd3:  v = 32'sd2086331;
      5'd4:  v = 32'sd1047214;
      5'd5:  v = 32'sd524117;
      5'd6:  v = 32'sd262123;
      5'd7:  v = 32'sd131069;
      5'd8:  v = 32'sd65536;
      5'd9:  v = 32'sd32768;
      5'd10: v = 32'sd16384;
      5'd11: v = 32'sd8192;
      5'd12: v = 32'sd4096;
      5'd13: v = 32'sd2048;
      5'd14: v = 32'sd1024;
      5'd15: v = 32'sd512;
      5'd16: v = 32'sd256;
      5'd17: v = 32'sd128;
      5'd18: v = 32'sd64;
      5'd19: v = 32'sd32;
      5'd20: v = 32'sd16;
      5'd21: v = 32'sd8;
      5'd22: v = 32'sd4;
      5'd23: v = 32'sd2;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/bug2_mul.sv
// Shared 64 by 64 unsigned multiplier built from four registered 32 by 32 partial products.
// Depends on nothing beyond its ports.
module bug2_mul (
  input  logic         clk,
  input  logic         start,
  input  logic         run,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] prod,
  output logic         last
);

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [63:0]  pp_r;
  logic [1:0]   pp_code_r;
  logic [127:0] acc_r;
  logic [2:0]   step_r;
  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [127:0] pp_shifted;

  assign a_half = step_r[1] ? a_r[63:32] : a_r[31:0];
  assign b_half = step_r[0] ? b_r[63:32] : b_r[31:0];

  always_comb begin
    case (pp_code_r)
      2'd0:    pp_shifted = {64'd0, pp_r};
      2'd3:    pp_shifted = {pp_r, 64'd0};
      default: pp_shifted = {32'd0, pp_r, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= a;
      b_r    <= b;
      acc_r  <= '0;
      step_r <= 3'd0;
    end else if (run) begin
      if (step_r != 3'd4) begin
        pp_r      <= a_half * b_half;
        pp_code_r <= step_r[1:0];
      end
      if (step_r != 3'd0) begin
        acc_r <= acc_r + pp_shifted;
      end
      step_r <= step_r + 3'd1;
    end
  end

  assign prod = acc_r;
  assign last = (step_r == 3'd4);

endmodule

FILE: rtl/bug2_ctrl.sv
// Sequencing state machine of the Bug2 controller: steps the datapath through each frame.
// Depends on bug2_pkg for the state, operation, command and status types.
module bug2_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bug2_pkg::status_t st,
  output bug2_pkg::cmd_t    cmd
);

  bug2_pkg::state_t state_r;
  bug2_pkg::state_t state_nxt;
  bug2_pkg::mop_t   mop_r;
  bug2_pkg::mop_t   mop_nxt;

  always_comb begin
    state_nxt = state_r;
    mop_nxt   = mop_r;
    case (state_r)
      bug2_pkg::S_IDLE: begin
        if (in_valid) begin
          if (st.wall_mode) begin
            state_nxt = bug2_pkg::S_MUL_LOAD;
            mop_nxt   = bug2_pkg::MOP_GXPY;
          end else begin
            state_nxt = bug2_pkg::S_CORD_INIT;
          end
        end
      end
      bug2_pkg::S_CORD_INIT: state_nxt = bug2_pkg::S_CORD_NORM;
      bug2_pkg::S_CORD_NORM: begin
        if (st.zero) begin
          state_nxt = bug2_pkg::S_ERR_INIT;
        end else if (st.norm_done) begin
          state_nxt = bug2_pkg::S_CORD_ITER;
        end
      end
      bug2_pkg::S_CORD_ITER: begin
        if (st.cord_last) begin
          state_nxt = bug2_pkg::S_ERR_INIT;
        end
      end
      bug2_pkg::S_ERR_INIT: state_nxt = bug2_pkg::S_ERR_WRAP;
      bug2_pkg::S_ERR_WRAP: begin
        if (st.err_ok) begin
          if (st.phase == bug2_pkg::PH_GO) begin
            state_nxt = bug2_pkg::S_MUL_LOAD;
            mop_nxt   = bug2_pkg::MOP_DX;
          end else begin
            state_nxt = bug2_pkg::S_DECIDE;
          end
        end
      end
      bug2_pkg::S_MUL_LOAD: state_nxt = bug2_pkg::S_MUL_RUN;
      bug2_pkg::S_MUL_RUN: begin
        if (st.mul_last) begin
          state_nxt = bug2_pkg::S_MUL_WB;
        end
      end
      bug2_pkg::S_MUL_WB: begin
        state_nxt = bug2_pkg::S_MUL_LOAD;
        case (mop_r)
          bug2_pkg::MOP_DX:   mop_nxt = bug2_pkg::MOP_DY;
          bug2_pkg::MOP_DY:   mop_nxt = bug2_pkg::MOP_GD;
          bug2_pkg::MOP_GXPY: mop_nxt = bug2_pkg::MOP_GYPX;
          bug2_pkg::MOP_GYPX: mop_nxt = bug2_pkg::MOP_GXGX;
          bug2_pkg::MOP_GXGX: mop_nxt = bug2_pkg::MOP_GYGY;
          bug2_pkg::MOP_GYGY: mop_nxt = bug2_pkg::MOP_LD;
          bug2_pkg::MOP_LD:   state_nxt = bug2_pkg::S_CROSS;
          bug2_pkg::MOP_CC:   mop_nxt = bug2_pkg::MOP_LG;
          default:            state_nxt = bug2_pkg::S_DECIDE;
        endcase
      end
      bug2_pkg::S_CROSS: begin
        state_nxt = bug2_pkg::S_MUL_LOAD;
        mop_nxt   = bug2_pkg::MOP_CC;
      end
      bug2_pkg::S_DECIDE: state_nxt = bug2_pkg::S_EMIT;
      bug2_pkg::S_EMIT: begin
        if (!st.res_has || st.out_free) begin
          state_nxt = bug2_pkg::S_IDLE;
        end
      end
      default: state_nxt = bug2_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.mop        = mop_r;
    cmd.load       = (state_r == bug2_pkg::S_IDLE) && in_valid;
    cmd.cord_init  = (state_r == bug2_pkg::S_CORD_INIT);
    cmd.cord_norm  = (state_r == bug2_pkg::S_CORD_NORM);
    cmd.cord_iter  = (state_r == bug2_pkg::S_CORD_ITER);
    cmd.err_init   = (state_r == bug2_pkg::S_ERR_INIT);
    cmd.err_wrap   = (state_r == bug2_pkg::S_ERR_WRAP);
    cmd.mul_load   = (state_r == bug2_pkg::S_MUL_LOAD);
    cmd.mul_run    = (state_r == bug2_pkg::S_MUL_RUN);
    cmd.mul_wb     = (state_r == bug2_pkg::S_MUL_WB);
    cmd.cross_calc = (state_r == bug2_pkg::S_CROSS);
    cmd.decide     = (state_r == bug2_pkg::S_DECIDE);
    cmd.emit       = (state_r == bug2_pkg::S_EMIT);
    in_stall       = (state_r != bug2_pkg::S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bug2_pkg::S_IDLE;
      mop_r   <= bug2_pkg::MOP_DX;
    end else begin
      state_r <= state_nxt;
      mop_r   <= mop_nxt;
    end
  end

endmodule

FILE: rtl/bug2_dp.sv
// Datapath of the Bug2 controller: registers, CORDIC, angle wrap, products and the decision.
// Depends on bug2_pkg and instantiates bug2_mul.
module bug2_dp #(
  parameter int CORDIC_STEPS = bug2_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bug2_pkg::in_word_t  in_data,
  input  logic                out_stall,
  output logic                out_valid,
  output bug2_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  bug2_pkg::cmd_t      cmd,
  output bug2_pkg::status_t   st
);

  localparam int CI_W = $clog2(CORDIC_STEPS);

  logic [15:0] obst_r;
  logic [15:0] fmin_r;
  logic [15:0] leave_r;
  logic [15:0] gdist_r;
  logic [14:0] ytol_r;
  logic [7:0]  tps_r;
  logic [7:0]  fsec_r;

  logic             wall_r;
  bug2_pkg::phase_t phase_r;
  logic [7:0]       tick_r;
  logic [7:0]       sec_r;

  bug2_pkg::in_word_t frm_r;
  logic signed [32:0] dx_r;
  logic signed [32:0] dy_r;
  logic               zero_r;

  logic signed [35:0]   cx_r;
  logic signed [35:0]   cy_r;
  logic signed [31:0]   cz_r;
  logic [CI_W-1:0]      ci_r;
  logic signed [31:0]   err_r;

  logic                 sign_r;
  logic [63:0]          sx_r;
  logic [64:0]          ssum_r;
  logic [31:0]          g2_r;
  logic [63:0]          p1_r;
  logic [63:0]          p2_r;
  logic [63:0]          gxx_r;
  logic [63:0]          gyy_r;
  logic [31:0]          l2_r;
  logic [63:0]          cabs_r;
  logic [63:0]          gsq_r;
  logic [127:0]         aa_r;
  logic                 near_r;

  bug2_pkg::out_word_t  res_r;
  bug2_pkg::out_word_t  res_nxt;
  logic                 res_has_r;
  logic                 res_has_nxt;
  logic                 out_valid_r;
  bug2_pkg::out_word_t  out_data_r;

  logic             wall_nxt;
  bug2_pkg::phase_t phase_nxt;
  logic [7:0]       tick_nxt;
  logic [7:0]       sec_nxt;

  logic signed [32:0] dx_in;
  logic signed [32:0] dy_in;
  logic [31:0]        agx;
  logic [31:0]        agy;
  logic [31:0]        apx;
  logic [31:0]        apy;
  logic [32:0]        adx;
  logic [32:0]        ady;
  logic [63:0]        mul_a;
  logic [63:0]        mul_b;
  logic [127:0]       prod;
  logic               mul_last;
  logic [63:0]        prod_lo;
  logic [63:0]        prod_signed;
  logic [63:0]        cross_diff;

  logic               big_x;
  logic               big_y;
  logic signed [35:0] xs;
  logic signed [35:0] ys;
  logic signed [31:0] at;
  logic               err_hi;
  logic               err_lo;
  logic [31:0]        abs_err;
  logic               off;
  logic               far;
  logic               cr, cc, cl, br, bc, bl;
  logic [7:0]         tick_base;
  logic [7:0]         sec_base;
  logic [7:0]         tick_inc;

  assign dx_in = {in_data.goal_x[31], in_data.goal_x} - {in_data.pos_x[31], in_data.pos_x};
  assign dy_in = {in_data.goal_y[31], in_data.goal_y} - {in_data.pos_y[31], in_data.pos_y};

  assign agx = frm_r.goal_x[31] ? 32'(-frm_r.goal_x) : 32'(frm_r.goal_x);
  assign agy = frm_r.goal_y[31] ? 32'(-frm_r.goal_y) : 32'(frm_r.goal_y);
  assign apx = frm_r.pos_x[31] ? 32'(-frm_r.pos_x) : 32'(frm_r.pos_x);
  assign apy = frm_r.pos_y[31] ? 32'(-frm_r.pos_y) : 32'(frm_r.pos_y);
  assign adx = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
  assign ady = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);

  always_comb begin
    case (cmd.mop)
      bug2_pkg::MOP_DX: begin
        mul_a = {31'd0, adx};
        mul_b = {31'd0, adx};
      end
      bug2_pkg::MOP_DY: begin
        mul_a = {31'd0, ady};
        mul_b = {31'd0, ady};
      end
      bug2_pkg::MOP_GD: begin
        mul_a = {48'd0, gdist_r};
        mul_b = {48'd0, gdist_r};
      end
      bug2_pkg::MOP_GXPY: begin
        mul_a = {32'd0, agx};
        mul_b = {32'd0, apy};
      end
      bug2_pkg::MOP_GYPX: begin
        mul_a = {32'd0, agy};
        mul_b = {32'd0, apx};
      end
      bug2_pkg::MOP_GXGX: begin
        mul_a = {32'd0, agx};
        mul_b = {32'd0, agx};
      end
      bug2_pkg::MOP_GYGY: begin
        mul_a = {32'd0, agy};
        mul_b = {32'd0, agy};
      end
      bug2_pkg::MOP_LD: begin
        mul_a = {48'd0, leave_r};
        mul_b = {48'd0, leave_r};
      end
      bug2_pkg::MOP_CC: begin
        mul_a = cabs_r;
        mul_b = cabs_r;
      end
      default: begin
        mul_a = {32'd0, l2_r};
        mul_b = gsq_r;
      end
    endcase
  end

  bug2_mul u_mul (
    .clk   (clk),
    .start (cmd.mul_load),
    .run   (cmd.mul_run),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (prod),
    .last  (mul_last)
  );

  assign prod_lo     = prod[63:0];
  assign prod_signed = sign_r ? 64'(-prod_lo) : prod_lo;
  assign cross_diff  = p1_r - p2_r;

  assign big_x = (cx_r >= 36'sh080000000) || (cx_r <= -36'sh080000000);
  assign big_y = (cy_r >= 36'sh080000000) || (cy_r <= -36'sh080000000);
  assign xs    = cx_r >>> ci_r;
  assign ys    = cy_r >>> ci_r;
  assign at    = bug2_pkg::atan_q24(bug2_pkg::ATAN_IDX_W'(ci_r));

  assign err_hi  = (err_r > bug2_pkg::PI_Q24);
  assign err_lo  = (err_r <= -bug2_pkg::PI_Q24);
  assign abs_err = err_r[31] ? 32'(-err_r) : 32'(err_r);
  assign off     = abs_err > {5'd0, ytol_r, 12'd0};
  assign far     = ssum_r[64] || (ssum_r[63:0] > {32'd0, g2_r});

  assign cr = frm_r.range_right > obst_r;
  assign cc = frm_r.range_front > obst_r;
  assign cl = frm_r.range_left  > obst_r;
  assign br = frm_r.range_right < obst_r;
  assign bc = frm_r.range_front < obst_r;
  assign bl = frm_r.range_left  < obst_r;

  always_comb begin
    res_nxt     = '0;
    res_has_nxt = 1'b0;
    wall_nxt    = wall_r;
    phase_nxt   = phase_r;
    tick_base   = tick_r;
    sec_base    = sec_r;
    if (!wall_r) begin
      case (phase_r)
        bug2_pkg::PH_TURN: begin
          res_has_nxt = 1'b1;
          if (off) begin
            if (!err_r[31] && (err_r != 32'sd0)) begin
              res_nxt = '{16'sd0, bug2_pkg::ANG_SLOW, bug2_pkg::ACT_TURN_LEFT};
            end else begin
              res_nxt = '{16'sd0, -bug2_pkg::ANG_SLOW, bug2_pkg::ACT_TURN_RIGHT};
            end
          end else begin
            res_nxt   = '{16'sd0, 16'sd0, bug2_pkg::ACT_ALIGNED};
            phase_nxt = bug2_pkg::PH_GO;
          end
        end
        bug2_pkg::PH_GO: begin
          if (far) begin
            res_nxt     = '{bug2_pkg::LIN_SPEED, 16'sd0, bug2_pkg::ACT_FORWARD};
            res_has_nxt = 1'b1;
          end else begin
            phase_nxt = bug2_pkg::PH_DONE;
          end
          if (off) begin
            phase_nxt = bug2_pkg::PH_TURN;
          end
        end
        default: begin
          res_nxt     = '{16'sd0, 16'sd0, bug2_pkg::ACT_GOAL_STOP};
          res_has_nxt = 1'b1;
        end
      endcase
      if ((frm_r.range_front < obst_r) && (frm_r.range_front > fmin_r)) begin
        tick_base = 8'd0;
        sec_base  = 8'd0;
        wall_nxt  = 1'b1;
      end
    end else begin
      if ((cr || br) && (cc || bc) && (cl || bl)) begin
        if ((cr && cc && cl) || (br && cc && bl)) begin
          res_nxt     = '{bug2_pkg::LIN_SPEED, -bug2_pkg::ANG_FAST, bug2_pkg::ACT_FIND_WALL};
          res_has_nxt = 1'b1;
        end else if (br && cc && cl) begin
          res_nxt     = '{bug2_pkg::LIN_SPEED, 16'sd0, bug2_pkg::ACT_FOLLOW};
          res_has_nxt = 1'b1;
        end else if (!(br && bc && bl)) begin
          res_nxt     = '{16'sd0, bug2_pkg::ANG_FAST, bug2_pkg::ACT_GO_LEFT};
          res_has_nxt = 1'b1;
        end
      end
      if ((sec_r > fsec_r) && near_r) begin
        wall_nxt = 1'b0;
      end
    end
    tick_inc = tick_base + 8'd1;
    if (tick_inc >= tps_r) begin
      tick_nxt = 8'd0;
      sec_nxt  = (sec_base == 8'd255) ? sec_base : sec_base + 8'd1;
    end else begin
      tick_nxt = tick_inc;
      sec_nxt  = sec_base;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frm_r  <= in_data;
      dx_r   <= dx_in;
      dy_r   <= dy_in;
      zero_r <= (dx_in == 33'sd0) && (dy_in == 33'sd0);
    end
    if (cmd.cord_init) begin
      cx_r <= 36'(dx_r);
      cy_r <= 36'(dy_r);
      cz_r <= 32'sd0;
      ci_r <= '0;
    end else if (cmd.cord_norm && !zero_r) begin
      if (!big_x && !big_y) begin
        cx_r <= cx_r <<< 1;
        cy_r <= cy_r <<< 1;
      end else if (cx_r < 36'sd0) begin
        if (cy_r >= 36'sd0) begin
          cx_r <= cy_r;
          cy_r <= -cx_r;
          cz_r <= bug2_pkg::HALF_PI_Q24;
        end else begin
          cx_r <= -cy_r;
          cy_r <= cx_r;
          cz_r <= -bug2_pkg::HALF_PI_Q24;
        end
      end
    end else if (cmd.cord_iter) begin
      if (cy_r >= 36'sd0) begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + at;
      end else begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - at;
      end
      ci_r <= ci_r + 1'b1;
    end
    if (cmd.err_init) begin
      err_r <= cz_r - {{4{frm_r.heading[15]}}, frm_r.heading, 12'd0};
    end else if (cmd.err_wrap) begin
      if (err_hi) begin
        err_r <= err_r - bug2_pkg::TWO_PI_Q24;
      end else if (err_lo) begin
        err_r <= err_r + bug2_pkg::TWO_PI_Q24;
      end
    end
    if (cmd.mul_load) begin
      case (cmd.mop)
        bug2_pkg::MOP_GXPY: sign_r <= frm_r.goal_x[31] ^ frm_r.pos_y[31];
        bug2_pkg::MOP_GYPX: sign_r <= frm_r.goal_y[31] ^ frm_r.pos_x[31];
        default:            sign_r <= 1'b0;
      endcase
    end
    if (cmd.mul_wb) begin
      case (cmd.mop)
        bug2_pkg::MOP_DX:   sx_r   <= prod_lo;
        bug2_pkg::MOP_DY:   ssum_r <= {1'b0, sx_r} + {1'b0, prod_lo};
        bug2_pkg::MOP_GD:   g2_r   <= prod[31:0];
        bug2_pkg::MOP_GXPY: p1_r   <= prod_signed;
        bug2_pkg::MOP_GYPX: p2_r   <= prod_signed;
        bug2_pkg::MOP_GXGX: gxx_r  <= prod_lo;
        bug2_pkg::MOP_GYGY: gyy_r  <= prod_lo;
        bug2_pkg::MOP_LD:   l2_r   <= prod[31:0];
        bug2_pkg::MOP_CC:   aa_r   <= prod;
        default:            near_r <= (aa_r < prod);
      endcase
    end
    if (cmd.cross_calc) begin
      cabs_r <= cross_diff[63] ? 64'(-cross_diff) : cross_diff;
      gsq_r  <= gxx_r + gyy_r;
    end
    if (cmd.decide) begin
      res_r <= res_nxt;
    end
    if (cmd.emit && res_has_r && st.out_free) begin
      out_data_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obst_r      <= 16'd6554;
      fmin_r      <= 16'd1966;
      leave_r     <= 16'd6554;
      gdist_r     <= 16'd6554;
      ytol_r      <= 15'd123;
      tps_r       <= 8'd30;
      fsec_r      <= 8'd5;
      wall_r      <= 1'b0;
      phase_r     <= bug2_pkg::PH_TURN;
      tick_r      <= 8'd0;
      sec_r       <= 8'd0;
      res_has_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          bug2_pkg::CFG_OBSTACLE:   obst_r  <= cfg_data;
          bug2_pkg::CFG_FRONT_MIN:  fmin_r  <= cfg_data;
          bug2_pkg::CFG_LEAVE_LINE: leave_r <= cfg_data;
          bug2_pkg::CFG_GOAL_DIST:  gdist_r <= cfg_data;
          bug2_pkg::CFG_YAW_TOL:    ytol_r  <= cfg_data[14:0];
          bug2_pkg::CFG_TICKS:      tps_r   <= cfg_data[7:0];
          bug2_pkg::CFG_FOLLOW_MIN: fsec_r  <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.decide) begin
        wall_r    <= wall_nxt;
        phase_r   <= phase_nxt;
        tick_r    <= tick_nxt;
        sec_r     <= sec_nxt;
        res_has_r <= res_has_nxt;
      end
      if (cmd.emit && res_has_r && st.out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    st.wall_mode = wall_r;
    st.phase     = phase_r;
    st.zero      = zero_r;
    st.norm_done = big_x || big_y;
    st.cord_last = (ci_r == CI_W'(CORDIC_STEPS - 1));
    st.err_ok    = !err_hi && !err_lo;
    st.mul_last  = mul_last;
    st.res_has   = res_has_r;
    st.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/bug2_navigation_controller.sv
// Top level of the Bug2 navigation controller: joins the sequencer and the datapath.
// Depends on bug2_pkg, bug2_ctrl and bug2_dp.
//
//   channel | ports                               | direction | word
//   --------+-------------------------------------+-----------+---------------------
//   in      | in_valid, in_stall, in_data         | in        | one sensor frame
//   out     | out_valid, out_stall, out_data      | out       | one velocity command
//   cfg     | cfg_valid, cfg_ready, cfg_index/data| in        | one register write
//
// In goal mode the CORDIC runs a normalising shift, then its rotation steps. A product on
// the shared 64 by 64 multiplier is built from 32 by 32 partial products; wall mode needs
// seven products, goal mode three in the go phase. A finished word waits in the output
// register while the next frame is taken in; a further word holds the input stalled until
// that register frees.
// Reset is synchronous; it loads the default configuration and clears mode, phase, timers and output valid.
module bug2_navigation_controller #(
  parameter int CORDIC_STEPS = bug2_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bug2_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bug2_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  bug2_pkg::cmd_t    cmd;
  bug2_pkg::status_t st;

  assign cfg_ready = 1'b1;

  bug2_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  bug2_dp #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
